>>> rtl/rtpdp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rtpdp_pkg
// Shared types and constants of the RTP L16/L24 audio depacketizer.
// ----------------------------------------------------------------------------
package rtpdp_pkg;

    // Default configuration of the core
    localparam int HEADER_BYTES_DEF     = 12;
    localparam int SAMPLES_PER_MS_DEF   = 48;
    localparam int MAX_PACKET_BYTES_DEF = 2048;

    // Datagram lengths that select a format
    localparam logic [10:0] LEN_L16_1MS = 11'd204;
    localparam logic [10:0] LEN_L24_1MS = 11'd300;
    localparam logic [10:0] LEN_L16_5MS = 11'd972;
    localparam logic [10:0] LEN_L24_5MS = 11'd1452;

    // Result kinds
    localparam logic KIND_SAMPLE = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    // Packet disposition
    typedef enum logic [1:0] {
        ST_PLAYED       = 2'd0,
        ST_WRONG_SENDER = 2'd1,
        ST_FMT_CHANGE   = 2'd2
    } t_pkt_status;

    // One result item as held in the output queue
    typedef struct packed {
        logic        result_kind;
        logic [31:0] sample_word;
        logic        channel;
        logic        sample_format;
        t_pkt_status packet_status;
        logic [15:0] sequence_number;
        logic [15:0] lost_packets;
    } t_result;

endpackage : rtpdp_pkg
`default_nettype wire

>>> rtl/rtp_pcm_depacketizer_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rtp_pcm_depacketizer_core
// Depacketizes RTP L16/L24 audio datagrams byte by byte.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_stall) carries one datagram byte per
//   transfer with its datagram length, sender address and last-byte mark.
//   Output channel (o_out_valid / i_out_stall) carries results: one audio
//   sample whenever a payload sample completes, and one status item on the
//   last byte of each datagram (after the sample that byte completes).
//   Configuration: i_cfg_wr_en writes i_cfg_wr_data into the accepted source
//   address; zero means learn from the first datagram. Write only when idle.
// Flow: a byte is registered at its transfer edge and processed once the
//   output queue has room for two results; its results enter the queue at
//   the edge that ends processing, and o_out_valid then rises.
// Throughput: one byte per cycle while the queue has room for two results.
//   A byte producing two results (sample plus status) pushes both; the
//   four-entry output queue absorbs that, and the input stalls only while it lacks room for two.
// Reset: synchronous, active low; clears the queue, the byte position, the
//   sequence tracking and the learned source; the format reverts to L24 1 ms.
// Stall: when i_out_stall holds the queue fills, the processing stage waits
//   and o_in_stall rises; no result is lost or repeated.
// ----------------------------------------------------------------------------
module rtp_pcm_depacketizer_core
    import rtpdp_pkg::*;
#(
    parameter int HEADER_BYTES     = HEADER_BYTES_DEF,
    parameter int SAMPLES_PER_MS   = SAMPLES_PER_MS_DEF,
    parameter int MAX_PACKET_BYTES = MAX_PACKET_BYTES_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // configuration
    input  wire logic        i_cfg_wr_en,
    input  wire logic [31:0] i_cfg_wr_data,
    // byte input
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [7:0]  i_data_byte,
    input  wire logic [10:0] i_packet_length,
    input  wire logic [31:0] i_sender_address,
    input  wire logic        i_last_byte,
    // result output
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic             o_result_kind,
    output logic [31:0]      o_sample_word,
    output logic             o_channel,
    output logic             o_sample_format,
    output logic [1:0]       o_packet_status,
    output logic [15:0]      o_sequence_number,
    output logic [15:0]      o_lost_packets
);

    localparam int POS_W = $clog2(MAX_PACKET_BYTES);
    localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_PACKET_BYTES - 1);
    localparam logic [POS_W-1:0] HDR     = POS_W'(HEADER_BYTES);
    localparam int SE_W = $clog2(10 * SAMPLES_PER_MS + 1);
    localparam logic [SE_W-1:0] LIMIT_1MS = SE_W'(2 * SAMPLES_PER_MS);
    localparam logic [SE_W-1:0] LIMIT_5MS = SE_W'(10 * SAMPLES_PER_MS);
    localparam int Q_DEPTH = 4;
    localparam int QP_W    = $clog2(Q_DEPTH);

    // ---------------- configuration ----------------
    logic [31:0] r_source_address;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_source_address <= '0;
        end else if (i_cfg_wr_en) begin
            r_source_address <= i_cfg_wr_data;
        end
    end

    // ---------------- input register ----------------
    logic        r_in_valid;
    logic [7:0]  r_data;
    logic [10:0] r_len;
    logic [31:0] r_sender;
    logic        r_last;
    logic        in_xfer;
    logic        proc;
    logic [QP_W:0] r_count;

    // Process only with room for two results in the queue.
    assign proc       = r_in_valid && (r_count <= (QP_W+1)'(Q_DEPTH - 2));
    assign o_in_stall = r_in_valid && !proc;
    assign in_xfer    = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_xfer) begin
            r_in_valid <= 1'b1;
        end else if (proc) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_data   <= i_data_byte;
            r_len    <= i_packet_length;
            r_sender <= i_sender_address;
            r_last   <= i_last_byte;
        end
    end

    // ---------------- depacketizer state ----------------
    logic [31:0]      r_learned;
    logic [10:0]      r_cur_len;
    logic             r_fmt_l24;
    logic             r_five_ms;
    logic [15:0]      r_prev_seq;
    logic             r_prev_valid;
    logic [POS_W-1:0] r_pos;
    logic [23:0]      r_asm;
    logic [SE_W-1:0]  r_se;
    t_pkt_status      r_action;
    logic [15:0]      r_seq;
    logic [1:0]       r_phase;

    logic [31:0]      n_learned;
    logic [10:0]      n_cur_len;
    logic             n_fmt_l24;
    logic             n_five_ms;
    logic [15:0]      n_prev_seq;
    logic             n_prev_valid;
    logic [POS_W-1:0] n_pos;
    logic [23:0]      n_asm;
    logic [SE_W-1:0]  n_se;
    t_pkt_status      n_action;
    logic [15:0]      n_seq;
    logic [1:0]       n_phase;

    logic [31:0]      src;
    logic [23:0]      asm_shift;
    logic             in_payload;
    logic             smp_done;
    logic [SE_W-1:0]  limit;
    logic [15:0]      lost;
    t_result          res_smp;
    t_result          res_sts;
    t_result          res_a;
    t_result          res_b;
    logic [1:0]       n_push;

    always_comb begin
        n_learned    = r_learned;
        n_cur_len    = r_cur_len;
        n_fmt_l24    = r_fmt_l24;
        n_five_ms    = r_five_ms;
        n_prev_seq   = r_prev_seq;
        n_prev_valid = r_prev_valid;
        n_pos        = r_pos;
        n_asm        = r_asm;
        n_se         = r_se;
        n_action     = r_action;
        n_seq        = r_seq;
        n_phase      = r_phase;
        src          = '0;
        asm_shift    = '0;
        smp_done     = 1'b0;
        lost         = '0;
        limit        = '0;
        in_payload   = 1'b0;

        // First byte: classify the datagram and restart per-packet tracking.
        if (r_pos == '0) begin
            src     = (r_source_address != '0) ? r_source_address : r_learned;
            n_seq   = '0;
            n_asm   = '0;
            n_se    = '0;
            n_phase = '0;
            if (src == '0) begin
                n_learned = r_sender;
                src       = r_sender;
            end
            if (src != '0 && r_sender != src) begin
                n_action = ST_WRONG_SENDER;
            end else if (r_len != r_cur_len) begin
                unique case (r_len)
                    LEN_L16_1MS: begin n_fmt_l24 = 1'b0; n_five_ms = 1'b0; end
                    LEN_L24_1MS: begin n_fmt_l24 = 1'b1; n_five_ms = 1'b0; end
                    LEN_L16_5MS: begin n_fmt_l24 = 1'b0; n_five_ms = 1'b1; end
                    LEN_L24_5MS: begin n_fmt_l24 = 1'b1; n_five_ms = 1'b1; end
                    default: ;
                endcase
                n_cur_len    = r_len;
                n_prev_valid = 1'b0;
                n_action     = ST_FMT_CHANGE;
            end else begin
                n_action = ST_PLAYED;
            end
        end

        // Sequence number from header bytes 2 and 3
        if (r_pos == POS_W'(2)) n_seq[15:8] = r_data;
        if (r_pos == POS_W'(3)) n_seq[7:0]  = r_data;

        // Payload: assemble big-endian samples; phase tracks the byte in sample.
        in_payload = (r_pos >= HDR) && (r_pos < POS_MAX);
        limit      = n_five_ms ? LIMIT_5MS : LIMIT_1MS;
        if (in_payload) begin
            n_phase = (n_phase == (n_fmt_l24 ? 2'd2 : 2'd1)) ? 2'd0 : n_phase + 2'd1;
            if (n_action == ST_PLAYED && n_se < limit) begin
                asm_shift = {n_asm[15:0], r_data};
                if (r_phase == (n_fmt_l24 ? 2'd2 : 2'd1)) begin
                    smp_done = 1'b1;
                    n_se     = n_se + SE_W'(1);
                    n_asm    = '0;
                end else begin
                    n_asm = asm_shift;
                end
            end
        end

        if (r_pos < POS_MAX) n_pos = r_pos + POS_W'(1);

        // Last byte: report the packet and rearm for the next one.
        if (r_last) begin
            if (n_action == ST_PLAYED) begin
                if (n_prev_valid) lost = n_seq - r_prev_seq - 16'd1;
                n_prev_seq   = n_seq;
                n_prev_valid = 1'b1;
            end
            n_pos    = '0;
            n_asm    = '0;
            n_se     = '0;
        end
    end

    // Sample selects its channel from the count before this sample.
    always_comb begin
        res_smp                 = '0;
        res_smp.result_kind     = KIND_SAMPLE;
        res_smp.sample_word     = n_fmt_l24 ? {asm_shift, 8'h00}
                                            : {16'h0000, asm_shift[15:0]};
        res_smp.channel         = (r_pos == '0) ? 1'b0 : r_se[0];
        res_smp.sample_format   = n_fmt_l24;
        res_smp.packet_status   = ST_PLAYED;

        res_sts                 = '0;
        res_sts.result_kind     = KIND_STATUS;
        res_sts.sample_format   = n_fmt_l24;
        res_sts.packet_status   = (r_pos == '0) ? n_action : r_action;
        res_sts.sequence_number = n_seq;
        res_sts.lost_packets    = lost;

        res_a  = smp_done ? res_smp : res_sts;
        res_b  = res_sts;
        n_push = proc ? ({1'b0, smp_done} + {1'b0, r_last}) : 2'd0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_learned    <= '0;
            r_cur_len    <= '0;
            r_fmt_l24    <= 1'b1;
            r_five_ms    <= 1'b0;
            r_prev_seq   <= '0;
            r_prev_valid <= 1'b0;
            r_pos        <= '0;
            r_asm        <= '0;
            r_se         <= '0;
            r_action     <= ST_PLAYED;
            r_seq        <= '0;
            r_phase      <= '0;
        end else if (proc) begin
            r_learned    <= n_learned;
            r_cur_len    <= n_cur_len;
            r_fmt_l24    <= n_fmt_l24;
            r_five_ms    <= n_five_ms;
            r_prev_seq   <= n_prev_seq;
            r_prev_valid <= n_prev_valid;
            r_pos        <= n_pos;
            r_asm        <= n_asm;
            r_se         <= n_se;
            r_action     <= n_action;
            r_seq        <= n_seq;
            r_phase      <= n_phase;
        end
    end

    // ---------------- output queue ----------------
    t_result          r_q [Q_DEPTH];
    logic [QP_W-1:0]  r_wr_ptr;
    logic [QP_W-1:0]  r_rd_ptr;
    logic             pop;

    assign o_out_valid = (r_count != '0);
    assign pop         = o_out_valid && !i_out_stall;

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < Q_DEPTH; i++) begin
            if (n_push != 2'd0 && QP_W'(i) == r_wr_ptr) begin
                r_q[i] <= res_a;
            end else if (n_push == 2'd2 && QP_W'(i) == r_wr_ptr + QP_W'(1)) begin
                r_q[i] <= res_b;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= r_wr_ptr + QP_W'(n_push);
            if (pop) r_rd_ptr <= r_rd_ptr + QP_W'(1);
            r_count <= r_count + (QP_W+1)'(n_push) - (QP_W+1)'(pop);
        end
    end

    assign o_result_kind     = r_q[r_rd_ptr].result_kind;
    assign o_sample_word     = r_q[r_rd_ptr].sample_word;
    assign o_channel         = r_q[r_rd_ptr].channel;
    assign o_sample_format   = r_q[r_rd_ptr].sample_format;
    assign o_packet_status   = 2'(r_q[r_rd_ptr].packet_status);
    assign o_sequence_number = r_q[r_rd_ptr].sequence_number;
    assign o_lost_packets    = r_q[r_rd_ptr].lost_packets;

endmodule : rtp_pcm_depacketizer_core
`default_nettype wire

>>> rtl/rtpdp_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rtpdp_checker
// Port-level checks of the depacketizer, bound to the top level.
// ----------------------------------------------------------------------------
module rtpdp_checker
    import rtpdp_pkg::*;
(
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_out_valid,
    input wire logic        i_out_stall,
    input wire logic        o_result_kind,
    input wire logic [31:0] o_sample_word,
    input wire logic        o_channel,
    input wire logic [1:0]  o_packet_status,
    input wire logic [15:0] o_sequence_number,
    input wire logic [15:0] o_lost_packets
);

    // Hold a stalled result.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_sample_word)
            && $stable(o_result_kind) && $stable(o_sequence_number))
        else $error("stalled result changed");

    // Reset empties the output queue.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result shown right after reset");

    // Sample transfers carry no packet status.
    a_sample_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_result_kind == KIND_SAMPLE |->
            o_packet_status == ST_PLAYED && o_sequence_number == 16'd0
            && o_lost_packets == 16'd0)
        else $error("sample carries status fields");

    // Status transfers carry no sample; loss counts only on played packets.
    a_status_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_result_kind == KIND_STATUS |->
            o_sample_word == 32'd0 && !o_channel
            && (o_packet_status == ST_PLAYED || o_lost_packets == 16'd0))
        else $error("status carries sample fields");

endmodule : rtpdp_checker

bind rtp_pcm_depacketizer_core rtpdp_checker u_rtpdp_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .o_out_valid       (o_out_valid),
    .i_out_stall       (i_out_stall),
    .o_result_kind     (o_result_kind),
    .o_sample_word     (o_sample_word),
    .o_channel         (o_channel),
    .o_packet_status   (o_packet_status),
    .o_sequence_number (o_sequence_number),
    .o_lost_packets    (o_lost_packets)
);
`default_nettype wire

>>> dv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks the RTP L16/L24 depacketizer core byte for byte against a behavioral
// predictor of its own. Directed datagrams cover source learning, wrong
// senders, every format length, sequence gaps with wrap, short and overlong
// datagrams. Random datagrams run under three source settings. Both channels
// idle at random, and one test holds the output off until the input stalls.
// ----------------------------------------------------------------------------
module testbench;
    import rtpdp_pkg::*;

    localparam int          CLK_HALF     = 6;
    localparam int          CYCLE_LIMIT  = 400000;
    localparam int          DRAIN_CYCLES = 10;
    localparam int          HOLD_CYCLES  = 300;
    localparam logic [10:0] POS_LAST     = 11'h7FF;
    localparam logic [31:0] HOST_A       = 32'hC0A8_0105;
    localparam logic [31:0] HOST_B       = 32'h0A00_0001;

    // ------------------------------------------------------------------
    // DUT signals; every input holds a known value from time zero
    // ------------------------------------------------------------------
    logic        clk           = 1'b0;
    logic        rst_n         = 1'b0;
    logic        cfg_wr_en     = 1'b0;
    logic [31:0] cfg_wr_data   = '0;
    logic        in_valid      = 1'b0;
    logic        in_stall;
    logic [7:0]  data_byte     = '0;
    logic [10:0] packet_length = '0;
    logic [31:0] sender_addr   = '0;
    logic        last_byte     = 1'b0;
    logic        out_valid;
    logic        out_stall     = 1'b0;
    logic        result_kind;
    logic [31:0] sample_word;
    logic        channel;
    logic        sample_format;
    logic [1:0]  packet_status;
    logic [15:0] sequence_number;
    logic [15:0] lost_packets;

    rtp_pcm_depacketizer_core dut (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_cfg_wr_en      (cfg_wr_en),
        .i_cfg_wr_data    (cfg_wr_data),
        .i_in_valid       (in_valid),
        .o_in_stall       (in_stall),
        .i_data_byte      (data_byte),
        .i_packet_length  (packet_length),
        .i_sender_address (sender_addr),
        .i_last_byte      (last_byte),
        .o_out_valid      (out_valid),
        .i_out_stall      (out_stall),
        .o_result_kind    (result_kind),
        .o_sample_word    (sample_word),
        .o_channel        (channel),
        .o_sample_format  (sample_format),
        .o_packet_status  (packet_status),
        .o_sequence_number(sequence_number),
        .o_lost_packets   (lost_packets)
    );

    // ------------------------------------------------------------------
    // Predictor state: a shadow of the depacketizer
    // ------------------------------------------------------------------
    logic [31:0] src_reg     = '0;   // source_address register
    logic [31:0] learned_src = '0;
    logic [10:0] cur_len     = '0;
    logic        fmt_l24     = 1'b1;
    logic        fmt_5ms     = 1'b0;
    logic [15:0] last_seq    = '0;
    logic        last_seq_ok = 1'b0;
    logic [10:0] byte_pos    = '0;
    logic [23:0] sample_acc  = '0;
    logic [9:0]  sample_cnt  = '0;
    t_pkt_status pkt_action  = ST_PLAYED;
    logic [15:0] seq_acc     = '0;

    // Predicted samples and status items, oldest first
    t_result     audio_out_q[$];

    // Sequence number for the next well-formed datagram
    logic [15:0] next_seq    = 16'h0100;

    // Idling controls
    logic        quiet_tx    = 1'b0;   // sender offers back to back
    logic        quiet_rx    = 1'b0;   // receiver never stalls
    logic        rx_hold     = 1'b0;   // long receiver hold-off
    int          rx_wait     = 0;

    int          n_errors    = 0;
    int          n_results   = 0;
    int          n_cycles    = 0;

    // ------------------------------------------------------------------
    // Clock, cycle limit
    // ------------------------------------------------------------------
    initial begin
        forever #(CLK_HALF) clk = ~clk;
    end

    always @(posedge clk) begin
        n_cycles++;
        if (n_cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results pending", n_cycles,
                     audio_out_q.size());
            $display("FAILED: results differ");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Predictor: work out what one accepted byte produces
    // ------------------------------------------------------------------
    task automatic depacketize_byte(input logic [7:0] data, input logic [10:0] len,
                                    input logic [31:0] snd, input logic last);
        logic [31:0] src;
        logic [15:0] lost;
        t_result     r;
        int          bps;
        int          lim;
        if (byte_pos == 0) begin
            src        = (src_reg != 0) ? src_reg : learned_src;
            seq_acc    = '0;
            sample_acc = '0;
            sample_cnt = '0;
            // learn the first sender while nothing is configured
            if (src == 0) begin
                learned_src = snd;
                src         = snd;
            end
            if (src != 0 && snd != src) begin
                pkt_action = ST_WRONG_SENDER;
            end else if (len != cur_len) begin
                // an unknown length keeps the format but still counts as a change
                case (len)
                    LEN_L16_1MS: begin fmt_l24 = 1'b0; fmt_5ms = 1'b0; end
                    LEN_L24_1MS: begin fmt_l24 = 1'b1; fmt_5ms = 1'b0; end
                    LEN_L16_5MS: begin fmt_l24 = 1'b0; fmt_5ms = 1'b1; end
                    LEN_L24_5MS: begin fmt_l24 = 1'b1; fmt_5ms = 1'b1; end
                    default: ;
                endcase
                cur_len     = len;
                last_seq_ok = 1'b0;
                pkt_action  = ST_FMT_CHANGE;
            end else begin
                pkt_action = ST_PLAYED;
            end
        end

        if (byte_pos == 11'd2) seq_acc[15:8] = data;
        if (byte_pos == 11'd3) seq_acc[7:0]  = data;

        if (pkt_action == ST_PLAYED && byte_pos >= HEADER_BYTES_DEF && byte_pos != POS_LAST)
        begin
            bps = fmt_l24 ? 3 : 2;
            lim = 2 * SAMPLES_PER_MS_DEF * (fmt_5ms ? 5 : 1);
            if (int'(sample_cnt) < lim) begin
                sample_acc = {sample_acc[15:0], data};
                if ((int'(byte_pos) - HEADER_BYTES_DEF) % bps == bps - 1) begin
                    r               = '0;
                    r.result_kind   = KIND_SAMPLE;
                    r.sample_word   = fmt_l24 ? {sample_acc, 8'h00}
                                              : {16'h0000, sample_acc[15:0]};
                    r.channel       = sample_cnt[0];
                    r.sample_format = fmt_l24;
                    r.packet_status = ST_PLAYED;
                    audio_out_q.push_back(r);
                    sample_cnt++;
                    sample_acc = '0;
                end
            end
        end

        // saturate the position on overlong datagrams
        if (byte_pos != POS_LAST) byte_pos++;

        if (last) begin
            lost = '0;
            if (pkt_action == ST_PLAYED) begin
                if (last_seq_ok) lost = seq_acc - last_seq - 16'd1;
                last_seq    = seq_acc;
                last_seq_ok = 1'b1;
            end
            r                 = '0;
            r.result_kind     = KIND_STATUS;
            r.sample_format   = fmt_l24;
            r.packet_status   = pkt_action;
            r.sequence_number = seq_acc;
            r.lost_packets    = lost;
            audio_out_q.push_back(r);
            byte_pos   = '0;
            sample_acc = '0;
            sample_cnt = '0;
            pkt_action = ST_PLAYED;
        end
    endtask

    // ------------------------------------------------------------------
    // Result side: random stalls, compare every transfer with the oldest
    // prediction
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        n_errors++;
        if (n_errors <= 40)
            $display("result %0d: %s got %h, expected %h", n_results, what, got, want);
    endtask

    always @(negedge clk) begin
        // hold stall for the drawn number of cycles, or for the whole hold-off
        out_stall <= rx_hold || (rx_wait != 0);
        if (rx_wait != 0) rx_wait = rx_wait - 1;
    end

    always @(posedge clk) begin
        t_result w;
        if (rst_n && out_valid && !out_stall) begin
            if (audio_out_q.size() == 0) begin
                report_mismatch("unexpected result, sample_word", sample_word, '0);
            end else begin
                w = audio_out_q.pop_front();
                if (result_kind != w.result_kind)
                    report_mismatch("result_kind", 32'(result_kind), 32'(w.result_kind));
                if (sample_word != w.sample_word)
                    report_mismatch("sample_word", sample_word, w.sample_word);
                if (channel != w.channel)
                    report_mismatch("channel", 32'(channel), 32'(w.channel));
                if (sample_format != w.sample_format)
                    report_mismatch("sample_format", 32'(sample_format),
                                    32'(w.sample_format));
                if (packet_status != w.packet_status)
                    report_mismatch("packet_status", 32'(packet_status),
                                    32'(w.packet_status));
                if (sequence_number != w.sequence_number)
                    report_mismatch("sequence_number", 32'(sequence_number),
                                    32'(w.sequence_number));
                if (lost_packets != w.lost_packets)
                    report_mismatch("lost_packets", 32'(lost_packets),
                                    32'(w.lost_packets));
            end
            n_results++;
            rx_wait = quiet_rx ? 0 : $urandom_range(0, 7);
        end
    end

    // ------------------------------------------------------------------
    // Byte side. Tasks start and end on a falling edge; after a transfer
    // valid stays high, so anything that waits must go through
    // wait_drained, which drops it first.
    // ------------------------------------------------------------------
    task automatic send_byte(input logic [7:0] b, input logic [10:0] len,
                             input logic [31:0] snd, input logic last);
        int gap;
        gap = quiet_tx ? 0 : $urandom_range(0, 7);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid      <= 1'b1;
        data_byte     <= b;
        packet_length <= len;
        sender_addr   <= snd;
        last_byte     <= last;
        // hold the payload until the transfer happens
        do @(posedge clk); while (in_stall);
        depacketize_byte(b, len, snd, last);
        @(negedge clk);
    endtask

    // Send one datagram: bytes 2 and 3 carry the sequence number, the rest is
    // random. Length and sender only count on the first byte; now and then
    // scramble them on the others.
    task automatic send_datagram(input logic [31:0] snd, input logic [10:0] len,
                                 input logic [15:0] seq, input int nbytes);
        logic [7:0] b;
        logic       scramble;
        scramble = ($urandom_range(0, 7) == 0);
        for (int i = 0; i < nbytes; i++) begin
            b = 8'($urandom_range(0, 255));
            if (i == 2) b = seq[15:8];
            if (i == 3) b = seq[7:0];
            if (i == 0 || !scramble)
                send_byte(b, len, snd, i == nbytes - 1);
            else
                send_byte(b, 11'($urandom_range(0, 2047)), $urandom, i == nbytes - 1);
        end
    endtask

    // Send a well-formed datagram that continues the sequence
    task automatic send_next(input logic [31:0] snd, input logic [10:0] len, input int nbytes);
        send_datagram(snd, len, next_seq, nbytes);
        next_seq++;
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (audio_out_q.size() != 0) @(negedge clk);
        // a byte that yields no result may still be in flight
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_source(input logic [31:0] v);
        wait_drained();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        src_reg = v;
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Right after reset: a zero sender is learned as zero, so everything is
    // accepted; length zero matches the reset length and plays as L24.
    task automatic test_zero_sender();
        next_seq = 16'h1234;
        send_next(32'h0, 11'd0, HEADER_BYTES_DEF + 3 * 3 + 2);   // partial sample dropped
        next_seq = 16'h1236;                                     // one lost
        send_next(32'h0, 11'd0, HEADER_BYTES_DEF + 6);
        wait_drained();
    endtask

    // Learn a real source, reject another, then walk sequence gaps and wrap.
    task automatic test_learn_source();
        send_datagram(HOST_A, LEN_L16_1MS, 16'h0000, 20);        // learned, format change
        send_datagram(HOST_B, LEN_L16_1MS, 16'h0001, 20);        // wrong sender
        next_seq = 16'hFFFE;
        send_next(HOST_A, LEN_L16_1MS, HEADER_BYTES_DEF + 8);
        next_seq = 16'h0001;                                     // wrap with two lost
        send_next(HOST_A, LEN_L16_1MS, HEADER_BYTES_DEF + 8);
        send_next(HOST_A, LEN_L16_1MS, HEADER_BYTES_DEF + 4);
        // short datagrams: missing sequence bytes read as zero
        send_datagram(HOST_A, LEN_L16_1MS, 16'hFFFF, 1);
        send_datagram(HOST_A, LEN_L16_1MS, 16'hA5FF, 3);
        send_datagram(HOST_A, LEN_L16_1MS, 16'h0000, HEADER_BYTES_DEF);
        wait_drained();
    endtask

    // Every format length, an unknown length and length zero
    task automatic test_formats();
        logic [10:0] lens[6];
        lens = '{LEN_L24_1MS, LEN_L16_5MS, LEN_L24_5MS, 11'd777, 11'd0, LEN_L16_1MS};
        foreach (lens[k]) begin
            send_datagram(HOST_A, lens[k], 16'($urandom), 20);
            send_next(HOST_A, lens[k], HEADER_BYTES_DEF + $urandom_range(0, 20));
            send_next(HOST_A, lens[k], HEADER_BYTES_DEF + $urandom_range(0, 20));
        end
        wait_drained();
    endtask

    // Payload beyond the sample count of the format
    task automatic test_overlong();
        quiet_tx = 1'b1;
        send_next(HOST_A, LEN_L16_1MS, HEADER_BYTES_DEF + 2 * 100);
        send_datagram(HOST_A, LEN_L24_1MS, 16'h0000, 16);
        send_next(HOST_A, LEN_L24_1MS, HEADER_BYTES_DEF + 3 * 100);
        quiet_tx = 1'b0;
        send_next(HOST_A, LEN_L24_1MS, HEADER_BYTES_DEF + 9);
        wait_drained();
    endtask

    // Configured source at both extremes; zero falls back to the learned one
    task automatic test_source_register();
        write_source(32'hFFFF_FFFF);
        send_datagram(32'hFFFF_FFFF, LEN_L24_5MS, 16'h0000, 14);
        send_next(32'hFFFF_FFFF, LEN_L24_5MS, HEADER_BYTES_DEF + 9);
        send_datagram(HOST_A, LEN_L24_5MS, 16'h0000, 14);        // now the wrong sender
        write_source(32'h0000_0000);
        send_datagram(32'hFFFF_FFFF, LEN_L24_5MS, 16'h0000, 14); // learned source rules
        send_next(HOST_A, LEN_L24_5MS, HEADER_BYTES_DEF + 6);
        wait_drained();
    endtask

    // Hold the output off long enough to fill the core and stall its input,
    // then pause the sender until every result is in.
    task automatic test_backpressure();
        quiet_tx = 1'b1;
        fork
            begin
                @(posedge clk);
                rx_hold = 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                rx_hold = 1'b0;
            end
            begin
                repeat (2) send_next(HOST_A, LEN_L24_5MS, HEADER_BYTES_DEF + 48);
            end
        join
        quiet_tx = 1'b0;
        wait_drained();
    endtask

    // Mostly well-formed datagrams with random content; the rest is wrong
    // senders, format changes and short datagrams.
    task automatic test_random(input int nbytes_goal);
        int          sent;
        int          pick;
        int          n;
        logic [31:0] acc;
        logic [10:0] len;
        sent = 0;
        while (sent < nbytes_goal) begin
            pick     = $urandom_range(0, 99);
            quiet_tx = ($urandom_range(0, 3) == 0);
            quiet_rx = ($urandom_range(0, 3) == 0);
            acc      = (src_reg != 0) ? src_reg : learned_src;
            if (pick < 70) begin
                if ($urandom_range(0, 9) == 0) next_seq = 16'($urandom);   // sequence jump
                n = HEADER_BYTES_DEF + $urandom_range(0, 30);
                send_next(acc, cur_len, n);
            end else if (pick < 80) begin
                n = $urandom_range(1, 30);
                send_datagram($urandom, 11'($urandom_range(0, 2047)), 16'($urandom), n);
            end else if (pick < 90) begin
                case ($urandom_range(0, 4))
                    0: len = LEN_L16_1MS;
                    1: len = LEN_L24_1MS;
                    2: len = LEN_L16_5MS;
                    3: len = LEN_L24_5MS;
                    default: len = 11'($urandom_range(0, 2047));
                endcase
                n = $urandom_range(1, 24);
                send_datagram(acc, len, 16'($urandom), n);
            end else begin
                n = $urandom_range(1, HEADER_BYTES_DEF - 1);
                send_datagram(acc, cur_len, 16'($urandom), n);
            end
            sent += n;
            if ($urandom_range(0, 29) == 0) wait_drained();
        end
        quiet_tx = 1'b0;
        quiet_rx = 1'b0;
        wait_drained();
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        repeat (2) @(negedge clk);

        test_zero_sender();
        test_learn_source();
        test_formats();
        test_overlong();
        test_source_register();
        test_backpressure();

        write_source($urandom | 32'h1);
        test_random(80);
        write_source(32'h0000_0000);
        test_random(80);
        write_source($urandom | 32'h8000_0000);
        test_random(80);

        wait_drained();
        if (n_errors == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

>>> rtp_pcm_depacketizer_core.f
rtl/rtpdp_pkg.sv
rtl/rtp_pcm_depacketizer_core.sv
rtl/rtpdp_checker.sv
dv/testbench.sv
